FILE: rtl/ship_pkg.sv
// shared types and constants for the rrip replacement unit
`timescale 1ns / 1ps

package ship_pkg;

  localparam int SIG_W    = 13;
  localparam int SET_IN_W = 11;
  localparam int WAY_IN_W = 4;
  localparam int THR_W    = 3;

  localparam logic [THR_W-1:0] THR_RESET = 3'd3;

  localparam logic MODE_VICTIM = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_MOD,
    ST_ROW,
    ST_OLD_MOD,
    ST_OLD,
    ST_NEW_MOD,
    ST_NEW,
    ST_SCAN,
    ST_AGE,
    ST_RESULT
  } state_t;

endpackage

FILE: rtl/ship_req_if.sv
// request channel: victim requests and access updates
`timescale 1ns / 1ps

interface ship_req_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [ship_pkg::SET_IN_W-1:0] set_index;
  logic [ship_pkg::WAY_IN_W-1:0] way_index;
  logic                         hit;
  logic [ship_pkg::SIG_W-1:0]    pc_low_bits;

  modport source (
    output valid, mode, set_index, way_index, hit, pc_low_bits,
    input  ready
  );
  modport sink (
    input  valid, mode, set_index, way_index, hit, pc_low_bits,
    output ready
  );
endinterface

FILE: rtl/ship_vic_if.sv
// result channel: chosen victim way
`timescale 1ns / 1ps

interface ship_vic_if;
  logic                         valid;
  logic                         ready;
  logic [ship_pkg::WAY_IN_W-1:0] victim_way;

  modport source (
    output valid, victim_way,
    input  ready
  );
  modport sink (
    input  valid, victim_way,
    output ready
  );
endinterface

FILE: rtl/ship_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module ship_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/ship_mod_reduce.sv
// remainder by a constant: reciprocal multiply, then one compare and subtract
`timescale 1ns / 1ps

module ship_mod_reduce #(
  parameter int IN_W    = 11,
  parameter int DIVISOR = 2048
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        start,
  input  logic [IN_W-1:0]                             value,
  output logic                                        done,
  output logic [(DIVISOR > 1 ? $clog2(DIVISOR) : 1)-1:0] result
);

  localparam int OUT_W = DIVISOR > 1 ? $clog2(DIVISOR) : 1;
  localparam int DW    = $clog2(DIVISOR + 1);
  localparam int W     = IN_W > DW ? IN_W : DW;
  localparam int MW    = IN_W + 1;
  localparam int PW    = IN_W + MW;
  localparam int QDW   = W + MW;
  // floor(2^IN_W / DIVISOR) leaves the quotient at most one short
  localparam int RECIP = (1 << IN_W) / DIVISOR;

  logic              stage_a;
  logic [IN_W-1:0]   val_a;
  logic [MW-1:0]     quo_a;
  logic [PW-1:0]     prod;
  logic [QDW-1:0]    qd;
  logic [W-1:0]      rem_est;
  logic [W-1:0]      rem_fix;

  assign prod    = PW'(value) * PW'(RECIP);
  assign qd      = QDW'(quo_a) * QDW'(DIVISOR);
  assign rem_est = W'(val_a) - qd[W-1:0];
  assign rem_fix = (rem_est >= W'(DIVISOR)) ? rem_est - W'(DIVISOR) : rem_est;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_a <= 1'b0;
      done    <= 1'b0;
    end else begin
      stage_a <= start;
      done    <= stage_a;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_a <= value;
      quo_a <= prod[PW-1:IN_W];
    end
    if (stage_a) begin
      result <= rem_fix[OUT_W-1:0];
    end
  end

endmodule

FILE: rtl/ship_rrip_replacement_unit.sv
// Signature-trained 2-bit rrip replacement for a set-associative cache. Each set row
// (re-reference values, reuse flags and signatures of all ways) lives in one row memory
// and the saturating reuse counters in a second memory; a small sequencer does one
// read-modify-write per request. After reset a clearing pass over all row and counter
// addresses initializes both memories while the request channel is held off (the
// threshold register can be written meanwhile). A request is taken only when the unit
// is idle. A victim request is dominated by the way scan that compares one way per
// cycle; a hit update only rewrites the row, and a miss update is dominated by the
// counter memory port (train old counter, then read the new one). Each index reduction
// is a reciprocal multiply and one correction, each result registered, whatever
// NUM_SETS and COUNTER_ENTRIES are. The result register holds a victim way until taken;
// the next request can be accepted meanwhile.
`timescale 1ns / 1ps

module ship_rrip_replacement_unit #(
  parameter int NUM_SETS        = 2048,
  parameter int NUM_WAYS        = 16,
  parameter int COUNTER_ENTRIES = 8192,
  parameter int RRPV_WIDTH      = 2,
  parameter int COUNTER_WIDTH   = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [ship_pkg::THR_W-1:0] cfg_wdata,
  ship_req_if.sink                   req,
  ship_vic_if.source                 resp
);

  import ship_pkg::*;

  localparam int SET_W     = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W     = $clog2(NUM_WAYS);
  localparam int CTR_IDX_W = $clog2(COUNTER_ENTRIES);
  localparam int ROW_W     = NUM_WAYS * (RRPV_WIDTH + 1 + SIG_W);
  localparam int CLR_DEPTH = NUM_SETS > COUNTER_ENTRIES ? NUM_SETS : COUNTER_ENTRIES;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  localparam logic [RRPV_WIDTH-1:0]    RRPV_TOP  = '1;
  localparam logic [RRPV_WIDTH-1:0]    RRPV_NEAR = RRPV_TOP - RRPV_WIDTH'(1);
  localparam logic [COUNTER_WIDTH-1:0] CTR_TOP   = '1;
  localparam logic [COUNTER_WIDTH-1:0] CTR_INIT  = CTR_TOP >> 1;

  state_t state, state_next;

  logic [CLR_W-1:0]         clr_cnt;
  logic [THR_W-1:0]         threshold;
  logic                     mode_r;
  logic                     hit_r;
  logic [WAY_W-1:0]         way_r;
  logic [SIG_W-1:0]         pc_r;
  logic [WAY_W-1:0]         scan_way;
  logic [RRPV_WIDTH-1:0]    top_r;
  logic [WAY_W-1:0]         victim_r;
  logic                     out_valid;
  logic [WAY_IN_W-1:0]      out_way;

  logic [NUM_WAYS-1:0][RRPV_WIDTH-1:0] rrpv_r, rrpv_q, rrpv_w;
  logic [NUM_WAYS-1:0]                 reuse_r, reuse_q, reuse_w;
  logic [NUM_WAYS-1:0][SIG_W-1:0]      sig_r, sig_q, sig_w;

  logic                     row_we, row_re;
  logic [SET_W-1:0]         row_waddr;
  logic [ROW_W-1:0]         row_wdata, row_rdata;
  logic                     ctr_we, ctr_re;
  logic [CTR_IDX_W-1:0]     ctr_waddr;
  logic [COUNTER_WIDTH-1:0] ctr_wdata, ctr_rdata, ctr_trained;
  logic                     set_start, set_done;
  logic [SET_W-1:0]         set_res;
  logic                     ctr_start, ctr_done;
  logic [SIG_W-1:0]         ctr_value;
  logic [CTR_IDX_W-1:0]     ctr_res;
  logic                     accept, way_ok, out_load;
  logic [RRPV_WIDTH-1:0]    gap;

  assign {sig_q, reuse_q, rrpv_q} = row_rdata;
  assign row_wdata = {sig_w, reuse_w, rrpv_w};

  assign accept   = req.valid && req.ready;
  assign way_ok   = 32'(req.way_index) < NUM_WAYS;
  assign gap      = RRPV_TOP - top_r;
  assign out_load = (state == ST_RESULT) && (!out_valid || resp.ready);

  assign req.ready       = (state == ST_IDLE);
  assign resp.valid      = out_valid;
  assign resp.victim_way = out_way;

  always_comb begin
    if (reuse_r[way_r]) begin
      ctr_trained = (ctr_rdata == CTR_TOP) ? ctr_rdata : ctr_rdata + COUNTER_WIDTH'(1);
    end else begin
      ctr_trained = (ctr_rdata == '0) ? ctr_rdata : ctr_rdata - COUNTER_WIDTH'(1);
    end
  end

  ship_mod_reduce #(
    .IN_W    (SET_IN_W),
    .DIVISOR (NUM_SETS)
  ) u_set_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (set_start),
    .value  (req.set_index),
    .done   (set_done),
    .result (set_res)
  );

  ship_mod_reduce #(
    .IN_W    (SIG_W),
    .DIVISOR (COUNTER_ENTRIES)
  ) u_ctr_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (ctr_start),
    .value  (ctr_value),
    .done   (ctr_done),
    .result (ctr_res)
  );

  ship_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (row_re),
    .raddr (set_res),
    .rdata (row_rdata)
  );

  ship_ram #(
    .WIDTH (COUNTER_WIDTH),
    .DEPTH (COUNTER_ENTRIES)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (ctr_wdata),
    .re    (ctr_re),
    .raddr (ctr_res),
    .rdata (ctr_rdata)
  );

  always_comb begin
    state_next = state;
    row_we     = 1'b0;
    row_re     = 1'b0;
    row_waddr  = set_res;
    ctr_we     = 1'b0;
    ctr_re     = 1'b0;
    ctr_waddr  = ctr_res;
    ctr_wdata  = ctr_trained;
    set_start  = 1'b0;
    ctr_start  = 1'b0;
    ctr_value  = pc_r;
    rrpv_w     = rrpv_r;
    reuse_w    = reuse_r;
    sig_w      = sig_r;

    unique case (state)
      ST_CLEAR: begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          rrpv_w[w]  = RRPV_TOP;
          reuse_w[w] = 1'b0;
          sig_w[w]   = '0;
        end
        row_we    = 32'(clr_cnt) < NUM_SETS;
        row_waddr = clr_cnt[SET_W-1:0];
        ctr_we    = 32'(clr_cnt) < COUNTER_ENTRIES;
        ctr_waddr = clr_cnt[CTR_IDX_W-1:0];
        ctr_wdata = CTR_INIT;
        if (clr_cnt == CLR_W'(CLR_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // updates to a way beyond the set are dropped
        if (accept && (req.mode == MODE_VICTIM || way_ok)) begin
          set_start  = 1'b1;
          state_next = ST_SET_MOD;
        end
      end
      ST_SET_MOD: begin
        if (set_done) begin
          row_re     = 1'b1;
          state_next = ST_ROW;
        end
      end
      ST_ROW: begin
        if (mode_r == MODE_VICTIM) begin
          state_next = ST_SCAN;
        end else if (hit_r) begin
          rrpv_w          = rrpv_q;
          reuse_w         = reuse_q;
          sig_w           = sig_q;
          rrpv_w[way_r]   = '0;
          reuse_w[way_r]  = 1'b1;
          row_we          = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          ctr_value  = sig_q[way_r];
          ctr_start  = 1'b1;
          state_next = ST_OLD_MOD;
        end
      end
      ST_OLD_MOD: begin
        if (ctr_done) begin
          ctr_re     = 1'b1;
          state_next = ST_OLD;
        end
      end
      ST_OLD: begin
        // train the evicted signature, then look up the new one
        ctr_we     = 1'b1;
        ctr_start  = 1'b1;
        state_next = ST_NEW_MOD;
      end
      ST_NEW_MOD: begin
        if (ctr_done) begin
          ctr_re     = 1'b1;
          state_next = ST_NEW;
        end
      end
      ST_NEW: begin
        sig_w[way_r]   = pc_r;
        reuse_w[way_r] = 1'b0;
        rrpv_w[way_r]  = (8'(ctr_rdata) > 8'(threshold)) ? '0 : RRPV_NEAR;
        row_we         = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_way == WAY_W'(NUM_WAYS - 1)) begin
          state_next = ST_AGE;
        end
      end
      ST_AGE: begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          rrpv_w[w] = rrpv_r[w] + gap;
        end
        row_we     = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      threshold <= THR_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (resp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= req.mode;
      hit_r  <= req.hit;
      way_r  <= WAY_W'(req.way_index);
      pc_r   <= req.pc_low_bits;
    end
    if (state == ST_ROW) begin
      rrpv_r   <= rrpv_q;
      reuse_r  <= reuse_q;
      sig_r    <= sig_q;
      scan_way <= '0;
      top_r    <= '0;
      victim_r <= '0;
    end
    if (state == ST_SCAN) begin
      // first way holding the largest value wins
      if (rrpv_r[scan_way] > top_r) begin
        top_r    <= rrpv_r[scan_way];
        victim_r <= scan_way;
      end
      scan_way <= scan_way + WAY_W'(1);
    end
    if (out_load) begin
      out_way <= WAY_IN_W'(victim_r);
    end
  end

endmodule

FILE: sim/tb_ship_rrip_replacement_unit.sv
// self-checking testbench for the signature-trained rrip replacement unit
`timescale 1ns / 1ps

module tb_ship_rrip_replacement_unit;
  import ship_pkg::*;

  localparam int NUM_SETS     = 2048;
  localparam int NUM_WAYS     = 16;
  localparam int CTR_ENTRIES  = 8192;
  localparam logic [1:0] RRPV_CEIL = 2'd3;
  localparam logic [2:0] CTR_MAX  = 3'd7;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 320;
  localparam int NUM_PHASES   = 6;

  typedef struct packed {
    logic                mode;
    logic [SET_IN_W-1:0] set_index;
    logic [WAY_IN_W-1:0] way_index;
    logic                hit;
    logic [SIG_W-1:0]    pc_low_bits;
  } req_item_t;

  // mirrors the per-way rrip state and the signature counters, queues victim predictions
  class victim_scoreboard;
    logic [1:0]          rrpv_mem [NUM_SETS*NUM_WAYS];
    logic                reused_mem [NUM_SETS*NUM_WAYS];
    logic [SIG_W-1:0]    sig_mem [NUM_SETS*NUM_WAYS];
    logic [2:0]          reuse_ctr [CTR_ENTRIES];
    logic [THR_W-1:0]    threshold;
    logic [WAY_IN_W-1:0] expected_victims [$];
    int                  mismatches;

    function new();
      foreach (rrpv_mem[i]) begin
        rrpv_mem[i]   = RRPV_CEIL;
        reused_mem[i] = 1'b0;
        sig_mem[i]    = '0;
      end
      foreach (reuse_ctr[i]) reuse_ctr[i] = CTR_MAX >> 1;
      threshold  = THR_RESET;
      mismatches = 0;
    endfunction

    // returns the predicted victim way for a victim request, -1 for an update
    function int note_request(req_item_t it);
      int base;
      int slot;
      int old_idx;
      int victim;
      logic [1:0] top;
      base = int'(it.set_index) * NUM_WAYS;
      slot = base + int'(it.way_index);
      if (it.mode == MODE_VICTIM) begin
        top = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (rrpv_mem[base+w] > top) top = rrpv_mem[base+w];
        end
        // age the whole set by the distance to the maximum
        for (int w = 0; w < NUM_WAYS; w++) begin
          rrpv_mem[base+w] = rrpv_mem[base+w] + (RRPV_CEIL - top);
        end
        victim = 0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
          if (rrpv_mem[base+w] == RRPV_CEIL) victim = w;
        end
        expected_victims.push_back(WAY_IN_W'(victim));
        return victim;
      end
      if (it.hit) begin
        rrpv_mem[slot]   = 2'd0;
        reused_mem[slot] = 1'b1;
        return -1;
      end
      // train the evicted signature, then install the new one
      old_idx = int'(sig_mem[slot]) % CTR_ENTRIES;
      if (reused_mem[slot]) begin
        if (reuse_ctr[old_idx] < CTR_MAX) reuse_ctr[old_idx] = reuse_ctr[old_idx] + 3'd1;
      end else if (reuse_ctr[old_idx] > 3'd0) begin
        reuse_ctr[old_idx] = reuse_ctr[old_idx] - 3'd1;
      end
      sig_mem[slot]    = it.pc_low_bits;
      reused_mem[slot] = 1'b0;
      if (reuse_ctr[int'(it.pc_low_bits) % CTR_ENTRIES] > threshold) rrpv_mem[slot] = 2'd0;
      else rrpv_mem[slot] = RRPV_CEIL - 2'd1;
      return -1;
    endfunction

    function void check_victim(logic [WAY_IN_W-1:0] got);
      logic [WAY_IN_W-1:0] want;
      if (expected_victims.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("victim_way %0d arrived with nothing pending", got);
        return;
      end
      want = expected_victims.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("victim_way mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [THR_W-1:0]    cfg_wdata;
  int                  cycle_count = 0;
  int                  idle_pct;
  int                  last_victim;
  logic                long_hold;
  event                start_long_hold;
  logic [SET_IN_W-1:0] hot_sets [6];
  logic [SIG_W-1:0]    sig_pool [8];
  victim_scoreboard    sb;

  ship_req_if req_ch();
  ship_vic_if vic_ch();

  ship_rrip_replacement_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .resp     (vic_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && vic_ch.valid && vic_ch.ready) sb.check_victim(vic_ch.victim_way);
  end

  // receiver: random stall bursts, plus one long hold-off
  initial begin
    int stall_left;
    vic_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        vic_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        vic_ch.ready <= 1'b0;
      end else if ($urandom_range(99) < idle_pct) begin
        stall_left = $urandom_range(0, 4);
        vic_ch.ready <= 1'b0;
      end else begin
        vic_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    long_hold = 1'b0;
    forever begin
      @(start_long_hold);
      @(posedge clk);
      long_hold = 1'b1;
      repeat (LONG_HOLD) @(posedge clk);
      long_hold = 1'b0;
    end
  end

  function automatic req_item_t mk(logic m, logic [SET_IN_W-1:0] s, logic [WAY_IN_W-1:0] w,
                                   logic h, logic [SIG_W-1:0] pc);
    return '{m, s, w, h, pc};
  endfunction

  // offer one item, hold it until taken, then maybe leave a gap
  task automatic issue(input req_item_t it);
    @(negedge clk);
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= it.mode;
    req_ch.set_index   <= it.set_index;
    req_ch.way_index   <= it.way_index;
    req_ch.hit         <= it.hit;
    req_ch.pc_low_bits <= it.pc_low_bits;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
    last_victim = sb.note_request(it);
    if ($urandom_range(99) < idle_pct) begin
      repeat ($urandom_range(1, 5)) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.expected_victims.size() != 0) @(posedge clk);
    // updates give no result, so let the last one finish
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.threshold = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    // every way hit so the whole set sits at zero and must age
    for (int w = 0; w < NUM_WAYS; w++) begin
      issue(mk(MODE_UPDATE, 11'd5, WAY_IN_W'(w), 1'b1, (w % 2) ? 13'h1FFF : 13'h0000));
    end
    issue(mk(MODE_VICTIM, 11'd5, 4'd0, 1'b0, 13'h0000));
    issue(mk(MODE_VICTIM, 11'd0, 4'd0, 1'b0, 13'h0000));
    issue(mk(MODE_VICTIM, 11'd2047, 4'd15, 1'b1, 13'h1FFF));
    // reused way trains its old signature up, a fresh one trains down
    issue(mk(MODE_UPDATE, 11'd5, 4'd0, 1'b0, 13'h1FFF));
    issue(mk(MODE_UPDATE, 11'd2047, 4'd15, 1'b0, 13'h0000));
    issue(mk(MODE_VICTIM, 11'd2047, 4'd0, 1'b0, 13'h0000));
    issue(mk(MODE_UPDATE, 11'd2047, 4'd15, 1'b1, 13'h1FFF));
    issue(mk(MODE_VICTIM, 11'd5, 4'd15, 1'b1, 13'h1FFF));
  endtask

  task automatic run_random(input int n);
    int sent;
    int kind;
    int pick;
    logic [SET_IN_W-1:0] s;
    logic [WAY_IN_W-1:0] w;
    foreach (hot_sets[i]) hot_sets[i] = SET_IN_W'($urandom);
    foreach (sig_pool[i]) sig_pool[i] = SIG_W'($urandom);
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(99);
      s = ($urandom_range(99) < 85) ? hot_sets[$urandom_range(5)] : SET_IN_W'($urandom);
      if (kind < 55) begin
        // victim, fill the chosen way, and maybe reuse it
        issue(mk(MODE_VICTIM, s, WAY_IN_W'($urandom), 1'($urandom), SIG_W'($urandom)));
        w = WAY_IN_W'(last_victim);
        pick = $urandom_range(7);
        issue(mk(MODE_UPDATE, s, w, 1'b0, sig_pool[pick]));
        sent += 2;
        // lower half of the pool are the signatures that get reused
        if ((pick < 4 && $urandom_range(99) < 80) || (pick >= 4 && $urandom_range(99) < 5)) begin
          issue(mk(MODE_UPDATE, s, w, 1'b1, SIG_W'($urandom)));
          sent++;
        end
      end else if (kind < 70) begin
        issue(mk(MODE_UPDATE, s, WAY_IN_W'($urandom), 1'b1, SIG_W'($urandom)));
        sent++;
      end else if (kind < 85) begin
        issue(mk(MODE_VICTIM, s, WAY_IN_W'($urandom), 1'($urandom), SIG_W'($urandom)));
        sent++;
      end else begin
        issue(mk(1'($urandom), SET_IN_W'($urandom), WAY_IN_W'($urandom), 1'($urandom),
                 SIG_W'($urandom)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [THR_W-1:0] thr_plan [NUM_PHASES];
    int idle_plan [NUM_PHASES];
    thr_plan  = '{3'd0, 3'd7, 3'd5, 3'd1, 3'd6, 3'd2};
    idle_plan = '{25, 15, 0, 35, 10, 0};
    sb = new();
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req_ch.valid       = 1'b0;
    req_ch.mode        = MODE_VICTIM;
    req_ch.set_index   = '0;
    req_ch.way_index   = '0;
    req_ch.hit         = 1'b0;
    req_ch.pc_low_bits = '0;
    idle_pct           = 20;
    last_victim        = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_threshold(thr_plan[p]);
      idle_pct = idle_plan[p];
      if (p == 1) -> start_long_hold;
      run_random(PHASE_ITEMS);
    end
    wait_drained();

    if (sb.mismatches == 0 && sb.expected_victims.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
